// ===== design/tcw_pkg.sv =====
// Shared constants, types and helpers for the text console writer.
// Used by tcw_text_ram, tcw_ctrl and text_console_writer_unit; no dependencies.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int ADDR_W = 11;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CMD_W  = 2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ATTR_W-1:0] attr_type;
   typedef logic [CMD_W-1:0]  cmd_type;

   localparam cmd_type CMD_PUT   = 2'd0;
   localparam cmd_type CMD_CLEAR = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   localparam char_type NEWLINE_CODE = 8'h0A;
   localparam char_type SPACE_CODE   = 8'h20;
   localparam attr_type RESET_ATTR   = 8'h0F;

   localparam addr_type LAST_CELL      = ADDR_W'(CELLS - 1);
   localparam addr_type LAST_ROW_START = ADDR_W'(CELLS - COLUMNS);
   localparam addr_type COLUMNS_ADDR   = ADDR_W'(COLUMNS);
   localparam col_type  LAST_COL       = COL_W'(COLUMNS - 1);
   localparam row_type  LAST_ROW       = ROW_W'(ROWS - 1);

   typedef struct packed {
      logic     en;
      addr_type addr;
      cell_type data;
   } ram_wr_type;

   typedef struct packed {
      logic     scrolled;
      cell_type cell_data;
      row_type  cursor_row;
      col_type  cursor_col;
   } result_type;

   function automatic addr_type cell_addr(input row_type row, input col_type col);
      return ADDR_W'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

// ===== design/text_console_writer_unit.sv =====
// Text console writer top level: sequencer, cell store and result register.
// Depends on tcw_pkg, tcw_ctrl and tcw_text_ram.
//
// Usage:
//   req channel: tuser carries the command (put, clear, read), tdata the
//   character and the cell index. rsp channel returns one result per request:
//   cursor after the operation, the cell read (zero otherwise), scroll flag.
//   csr_wr_en/csr_wr_data set the attribute byte for written and blank cells;
//   write it only while no request is in flight.
// Sequencing:
//   put without scroll, and cmd 3: the result is registered in S_DONE and the
//   next request is taken only after it leaves. read: the store read is
//   registered, S_RWAIT captures the cell, then S_DONE. clear: one cell
//   written per cycle over 2000 cells. scroll (newline or wrap on the bottom
//   row): the copy moves one cell per cycle through the single read and write
//   port of the store, then blanks the 80-cell last row.
// Reset: a fill pass writes every one of the 2000 cells to space on attribute
//   0x0F; req_tready stays low until it ends.
// Stall: one result waits in the output register while the next request is
//   accepted and worked; the sequencer then holds until rsp_tready frees it.
module text_console_writer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], cell_index[18:8], zero[23:19]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // cursor_col[6:0], cursor_row[11:7],
                                    // cell_data[27:12], scrolled[28], zero[31:29]
);
   import tcw_pkg::*;

   ram_wr_type wr;
   addr_type   rd_addr;
   cell_type   rd_data;
   result_type res;
   logic       res_valid;
   logic       res_take;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   tcw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_index   (req_tdata[18:8]),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .wr          (wr),
      .res         (res),
      .res_valid   (res_valid),
      .res_take    (res_take)
   );

   tcw_text_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff};

endmodule

// ===== design/tcw_text_ram.sv =====
// Character cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for depth and widths.
module tcw_text_ram (
   input  logic               clock,
   input  tcw_pkg::ram_wr_type wr,
   input  tcw_pkg::addr_type   rd_addr,
   output tcw_pkg::cell_type   rd_data
);
   import tcw_pkg::*;

   cell_type mem [CELLS];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tcw_ctrl.sv =====
// Command sequencer: cursor, attribute register, and the sweeps for reset fill,
// clear, scroll copy and last-row blanking. Depends on tcw_pkg.
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  tcw_pkg::attr_type   csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcw_pkg::cmd_type    req_cmd,
   input  tcw_pkg::char_type   req_char,
   input  tcw_pkg::addr_type   req_index,
   output tcw_pkg::addr_type   rd_addr,
   input  tcw_pkg::cell_type   rd_data,
   output tcw_pkg::ram_wr_type wr,
   output tcw_pkg::result_type res,
   output logic                res_valid,
   input  logic                res_take
);
   import tcw_pkg::*;

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_RWAIT = 7'b0000100,
      S_COPY  = 7'b0001000,
      S_BLANK = 7'b0010000,
      S_FILL  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   addr_type  cnt_ff, cnt_in;
   col_type   col_ff, col_in;
   row_type   row_ff, row_in;
   attr_type  attr_ff, attr_in;
   logic      pend_ff, pend_in;
   addr_type  pwa_ff, pwa_in;
   logic      inrange_ff, inrange_in;
   cell_type  data_ff, data_in;
   logic      scrolled_ff, scrolled_in;
   logic      accept;
   cell_type  blank;

   assign blank     = {attr_ff, SPACE_CODE};
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == S_DONE);
   assign res       = '{scrolled: scrolled_ff, cell_data: data_ff,
                        cursor_row: row_ff, cursor_col: col_ff};
   assign attr_in   = csr_wr_en ? csr_wr_data : attr_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pend_in     = 1'b0;
      pwa_in      = pwa_ff;
      inrange_in  = inrange_ff;
      data_in     = data_ff;
      scrolled_in = scrolled_ff;
      wr          = '{en: 1'b0, addr: '0, data: '0};
      rd_addr     = cnt_ff;
      case (state_ff)
         S_INIT: begin
            wr = '{en: 1'b1, addr: cnt_ff, data: {RESET_ATTR, SPACE_CODE}};
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            rd_addr = req_index;
            if (req_valid) begin
               data_in     = '0;
               scrolled_in = 1'b0;
               state_in    = S_DONE;
               case (req_cmd)
                  CMD_PUT: begin
                     if (req_char != NEWLINE_CODE) begin
                        wr = '{en: 1'b1, addr: cell_addr(row_ff, col_ff),
                               data: {attr_ff, req_char}};
                     end
                     if (req_char == NEWLINE_CODE || col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           scrolled_in = 1'b1;
                           cnt_in      = COLUMNS_ADDR;
                           state_in    = S_COPY;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = S_FILL;
                  end
                  CMD_READ: begin
                     inrange_in = (req_index <= LAST_CELL);
                     state_in   = S_RWAIT;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_RWAIT: begin
            data_in  = inrange_ff ? rd_data : '0;
            state_in = S_DONE;
         end
         S_COPY: begin
            pend_in = 1'b1;
            pwa_in  = cnt_ff - COLUMNS_ADDR;
            if (pend_ff) begin
               wr = '{en: 1'b1, addr: pwa_ff, data: rd_data};
            end
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = LAST_ROW_START;
               state_in = S_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_BLANK: begin
            if (pend_ff) begin
               wr = '{en: 1'b1, addr: pwa_ff, data: rd_data};
            end else begin
               wr = '{en: 1'b1, addr: cnt_ff, data: blank};
               if (cnt_ff == LAST_CELL) begin
                  state_in = S_DONE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_FILL: begin
            wr = '{en: 1'b1, addr: cnt_ff, data: blank};
            if (cnt_ff == LAST_CELL) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         attr_ff  <= RESET_ATTR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         attr_ff  <= attr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pwa_ff      <= pwa_in;
      inrange_ff  <= inrange_in;
      data_ff     <= data_in;
      scrolled_ff <= scrolled_in;
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= LAST_COL) && (row_ff <= LAST_ROW))
      else $error("cursor out of range");

   a_pend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_COPY || state_ff == S_BLANK))
      else $error("pending copy write outside scroll");

   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (wr.addr <= LAST_CELL))
      else $error("write beyond cell store");

   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_READ) |=> (state_ff == S_RWAIT))
      else $error("read request skipped data wait");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (res_valid && scrolled_ff) |-> (row_ff == LAST_ROW && col_ff == '0))
      else $error("scroll left cursor off bottom row start");

endmodule
